// File: rtl/smcp_pkg.sv
// shared constants, types and event codes for the serial motor command parser
package smcp_pkg;

	localparam int unsigned ByteW         = 8;
	localparam int unsigned WordW         = 32;
	localparam int unsigned WordBytes     = WordW / ByteW;
	localparam int unsigned GainCount     = 3;
	localparam int unsigned GainBytes     = GainCount * WordBytes;
	localparam int unsigned SetpointBytes = WordBytes;
	localparam int unsigned StoreDepth    = GainBytes;
	localparam int unsigned SlotW         = $clog2(StoreDepth);
	localparam int unsigned CountW        = 4;
	localparam int unsigned CfgIdxW       = 2;
	localparam int unsigned EventW        = 3;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgOpGains    = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgOpStart    = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgOpStop     = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgOpSetpoint = 2'd3;

	// opcode values after reset
	localparam logic [ByteW-1:0] RstOpGains    = 8'd1;
	localparam logic [ByteW-1:0] RstOpStart    = 8'd2;
	localparam logic [ByteW-1:0] RstOpStop     = 8'd3;
	localparam logic [ByteW-1:0] RstOpSetpoint = 8'd4;

	localparam logic [CountW-1:0] GainCount4     = CountW'(GainBytes);
	localparam logic [CountW-1:0] SetpointCount4 = CountW'(SetpointBytes);

	typedef enum logic [EventW-1:0] {
		EV_NONE     = 3'd0,
		EV_START    = 3'd1,
		EV_STOP     = 3'd2,
		EV_GAINS    = 3'd3,
		EV_SETPOINT = 3'd4
	} event_t;

	// payload kind being collected
	typedef enum logic {
		KIND_GAINS    = 1'b0,
		KIND_SETPOINT = 1'b1
	} kind_t;

	// write request into the payload buffer
	typedef struct packed {
		logic             en;
		logic [SlotW-1:0] slot;
	} payload_wr_t;

endpackage

// File: rtl/smcp_payload.sv
// payload byte buffer with big-endian word assembly
module smcp_payload (
	input  logic                                                clk,
	input  smcp_pkg::payload_wr_t                               wr,
	input  logic [smcp_pkg::ByteW-1:0]                          wr_byte,
	output logic [smcp_pkg::GainCount-1:0][smcp_pkg::WordW-1:0] words
);

	logic [smcp_pkg::ByteW-1:0] store_q [smcp_pkg::StoreDepth];
	logic [smcp_pkg::ByteW-1:0] view    [smcp_pkg::StoreDepth];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_q[wr.slot] <= wr_byte;
		end
	end

	// buffer contents as they stand once the current byte is in
	always_comb begin
		for (int k = 0; k < smcp_pkg::StoreDepth; k++) begin
			if (wr.en && (wr.slot == smcp_pkg::SlotW'(k))) begin
				view[k] = wr_byte;
			end else begin
				view[k] = store_q[k];
			end
		end
	end

	always_comb begin
		for (int w = 0; w < smcp_pkg::GainCount; w++) begin
			for (int b = 0; b < smcp_pkg::WordBytes; b++) begin
				words[w][(smcp_pkg::WordBytes-1-b)*smcp_pkg::ByteW +: smcp_pkg::ByteW] =
					view[w*smcp_pkg::WordBytes + b];
			end
		end
	end

endmodule

// File: rtl/serial_motor_command_parser.sv
// top level of the serial motor command parser
// Takes one received serial byte per input beat and returns exactly one result beat per
// byte, in order. A byte that matches the gains opcode arms a 12-byte payload, the
// setpoint opcode arms a 4-byte payload, start and stop set and clear run_enable, and
// other bytes are ignored. When the last payload byte arrives its big-endian signed
// words are latched into gain_p, gain_i, gain_d or position_target. Each result carries
// an event code and the register values after that byte. Throughput is one byte per
// clock cycle unless out_stall holds a result: the byte is captured in an input register
// and then decoded into the result register. There is no buffer beyond these two
// registers, so in_stall rises while a result waits under out_stall and the input register
// is occupied. Opcode registers are written through the cfg port, which is always ready,
// and should be changed only while the parser is idle.
module serial_motor_command_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [smcp_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [smcp_pkg::ByteW-1:0]          cfg_data,
	// input byte channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [smcp_pkg::ByteW-1:0]          rx_byte,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [smcp_pkg::EventW-1:0]         event_res,
	output logic                                run_enable,
	output logic signed [smcp_pkg::WordW-1:0]   gain_p,
	output logic signed [smcp_pkg::WordW-1:0]   gain_i,
	output logic signed [smcp_pkg::WordW-1:0]   gain_d,
	output logic signed [smcp_pkg::WordW-1:0]   position_target
);

	// opcode registers
	logic [smcp_pkg::ByteW-1:0] op_gains_q;
	logic [smcp_pkg::ByteW-1:0] op_start_q;
	logic [smcp_pkg::ByteW-1:0] op_stop_q;
	logic [smcp_pkg::ByteW-1:0] op_setpoint_q;

	// input register
	logic                       valid_s1;
	logic [smcp_pkg::ByteW-1:0] byte_s1;

	// parser state
	logic [smcp_pkg::CountW-1:0] bytes_left_q;
	logic [smcp_pkg::CountW-1:0] write_pos_q;
	smcp_pkg::kind_t             kind_q;
	logic                        run_q;

	// result register (latched words double as the snapshot outputs)
	logic                                           out_valid_q;
	smcp_pkg::event_t                               event_q;
	logic [smcp_pkg::GainCount-1:0][smcp_pkg::WordW-1:0] gains_q;
	logic [smcp_pkg::WordW-1:0]                     target_q;

	// next-state signals
	logic                                           advance;
	logic                                           idle;
	logic                                           last_byte;
	logic [smcp_pkg::CountW-1:0]                    slot_full;
	smcp_pkg::payload_wr_t                          wr;
	logic [smcp_pkg::GainCount-1:0][smcp_pkg::WordW-1:0] words;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_gains_q    <= smcp_pkg::RstOpGains;
			op_start_q    <= smcp_pkg::RstOpStart;
			op_stop_q     <= smcp_pkg::RstOpStop;
			op_setpoint_q <= smcp_pkg::RstOpSetpoint;
		end else if (cfg_valid) begin
			case (cfg_index)
				smcp_pkg::CfgOpGains:    op_gains_q    <= cfg_data;
				smcp_pkg::CfgOpStart:    op_start_q    <= cfg_data;
				smcp_pkg::CfgOpStop:     op_stop_q     <= cfg_data;
				smcp_pkg::CfgOpSetpoint: op_setpoint_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the held byte moves on whenever the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign idle      = (bytes_left_q == '0);
	assign last_byte = (bytes_left_q == smcp_pkg::CountW'(1));

	// slot index wraps at the buffer depth
	always_comb begin
		if (write_pos_q >= smcp_pkg::CountW'(smcp_pkg::StoreDepth)) begin
			slot_full = write_pos_q - smcp_pkg::CountW'(smcp_pkg::StoreDepth);
		end else begin
			slot_full = write_pos_q;
		end
		wr.en   = advance && !idle;
		wr.slot = slot_full[smcp_pkg::SlotW-1:0];
	end

	smcp_payload u_payload (
		.clk     (clk),
		.wr      (wr),
		.wr_byte (byte_s1),
		.words   (words)
	);

	// decode and state update, one byte per cycle while advance is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			write_pos_q  <= '0;
			kind_q       <= smcp_pkg::KIND_GAINS;
			run_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			event_q      <= smcp_pkg::EV_NONE;
			gains_q      <= '0;
			target_q     <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				event_q     <= smcp_pkg::EV_NONE;
				if (idle) begin
					// opcode match, first hit in register order wins
					if (byte_s1 == op_gains_q) begin
						bytes_left_q <= smcp_pkg::GainCount4;
						kind_q       <= smcp_pkg::KIND_GAINS;
					end else if (byte_s1 == op_start_q) begin
						run_q   <= 1'b1;
						event_q <= smcp_pkg::EV_START;
					end else if (byte_s1 == op_stop_q) begin
						run_q   <= 1'b0;
						event_q <= smcp_pkg::EV_STOP;
					end else if (byte_s1 == op_setpoint_q) begin
						bytes_left_q <= smcp_pkg::SetpointCount4;
						kind_q       <= smcp_pkg::KIND_SETPOINT;
					end
				end else begin
					// payload byte
					bytes_left_q <= bytes_left_q - smcp_pkg::CountW'(1);
					if (last_byte) begin
						write_pos_q <= '0;
						if (kind_q == smcp_pkg::KIND_GAINS) begin
							gains_q <= words;
							event_q <= smcp_pkg::EV_GAINS;
						end else begin
							target_q <= words[0];
							event_q  <= smcp_pkg::EV_SETPOINT;
						end
					end else begin
						write_pos_q <= write_pos_q + smcp_pkg::CountW'(1);
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign event_res       = event_q;
	assign run_enable      = run_q;
	assign gain_p          = gains_q[0];
	assign gain_i          = gains_q[1];
	assign gain_d          = gains_q[2];
	assign position_target = target_q;

endmodule

// File: sim/serial_motor_command_parser_tb.sv
// self-checking testbench for serial_motor_command_parser: directed table, then random commands
module serial_motor_command_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PeriodNs   = 8;
	localparam int IdlePct    = 32;      // chance per cycle that a side idles or stalls
	localparam int HoldCycles = 60;      // long receiver hold-off, fills the parser
	localparam int PhaseItems = 180;     // random bytes per opcode setting
	localparam int TailCycles = 8;       // idle tail before the final report
	localparam int CycleLimit = 200000;

	// one status beat: event plus the register snapshot after the byte
	typedef struct packed {
		smcp_pkg::event_t ev;
		logic             run;
		logic [31:0]      p;
		logic [31:0]      i;
		logic [31:0]      d;
		logic [31:0]      t;
	} result_t;

	// directed row: the byte, and a typed status where it is obvious by eye
	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		result_t    status;
	} byte_row_t;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [smcp_pkg::CfgIdxW-1:0]      cfg_index;
	logic [smcp_pkg::ByteW-1:0]        cfg_data;
	logic                              in_valid;
	logic                              in_stall;
	logic [smcp_pkg::ByteW-1:0]        rx_byte;
	logic                              out_valid;
	logic                              out_stall;
	logic [smcp_pkg::EventW-1:0]       event_res;
	logic                              run_enable;
	logic signed [smcp_pkg::WordW-1:0] gain_p;
	logic signed [smcp_pkg::WordW-1:0] gain_i;
	logic signed [smcp_pkg::WordW-1:0] gain_d;
	logic signed [smcp_pkg::WordW-1:0] position_target;

	serial_motor_command_parser uut (.*);

	always #(PeriodNs / 2) clk = ~clk;

	// directed bytes under the reset opcodes: unknown extremes, repeated start and stop,
	// a gain payload of extreme words, then a setpoint whose payload looks like opcodes
	byte_row_t directed_rows [25] = '{
		'{8'h00, 1'b1, '{smcp_pkg::EV_NONE, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0}},
		'{8'hFF, 1'b1, '{smcp_pkg::EV_NONE, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0}},
		'{smcp_pkg::RstOpStart, 1'b1,
			'{smcp_pkg::EV_START, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0}},
		'{smcp_pkg::RstOpStart, 1'b1,
			'{smcp_pkg::EV_START, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0}},
		'{smcp_pkg::RstOpStop, 1'b1,
			'{smcp_pkg::EV_STOP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0}},
		'{smcp_pkg::RstOpStop, 1'b1,
			'{smcp_pkg::EV_STOP, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0}},
		'{smcp_pkg::RstOpStart, 1'b1,
			'{smcp_pkg::EV_START, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0}},
		'{smcp_pkg::RstOpGains, 1'b1,
			'{smcp_pkg::EV_NONE, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0}},
		'{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
		'{8'h7F, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b1,
			'{smcp_pkg::EV_GAINS, 1'b1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0}},
		'{smcp_pkg::RstOpSetpoint, 1'b1,
			'{smcp_pkg::EV_NONE, 1'b1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0}},
		'{smcp_pkg::RstOpStop, 1'b0, '0}, '{smcp_pkg::RstOpStart, 1'b0, '0},
		'{smcp_pkg::RstOpGains, 1'b0, '0},
		'{smcp_pkg::RstOpSetpoint, 1'b1,
			'{smcp_pkg::EV_SETPOINT, 1'b1, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
				32'h03020104}}
	};

	// parser state as the checker sees it
	logic [7:0]  pred_op [4] = '{smcp_pkg::RstOpGains, smcp_pkg::RstOpStart,
		smcp_pkg::RstOpStop, smcp_pkg::RstOpSetpoint};
	logic [3:0]  pend_left = '0;
	smcp_pkg::kind_t pend_kind = smcp_pkg::KIND_GAINS;
	logic [3:0]  wr_pos = '0;
	logic [7:0]  pay_store [smcp_pkg::StoreDepth];
	logic        run_flag = 1'b0;
	logic [31:0] gain_word [3] = '{32'h0, 32'h0, 32'h0};
	logic [31:0] target_word = '0;

	// opcodes currently programmed, used by the stimulus to build commands
	logic [7:0]  cur_op [4] = '{smcp_pkg::RstOpGains, smcp_pkg::RstOpStart,
		smcp_pkg::RstOpStop, smcp_pkg::RstOpSetpoint};

	result_t     queued_status [$];
	logic        row_typed;
	result_t     row_status;
	bit          quiet = 1'b0;       // no idling on either side
	bit          hold_phase = 1'b0;  // receiver does one long hold-off
	int          mismatches = 0;
	int          beats_checked = 0;
	int          items_sent = 0;
	int          settings = 1;
	int          ev_count [5] = '{0, 0, 0, 0, 0};
	int          cycle_count = 0;

	function automatic logic [31:0] word_at(int base);
		return {pay_store[base], pay_store[base+1], pay_store[base+2], pay_store[base+3]};
	endfunction

	// advance the parser state by one byte and return the status beat it produces
	function automatic result_t decode_byte(logic [7:0] b);
		result_t     r;
		int unsigned slot;
		r = '0;
		r.ev = smcp_pkg::EV_NONE;
		if (pend_left == 0) begin
			// opcode order matters when two registers hold the same value
			if (b == pred_op[smcp_pkg::CfgOpGains]) begin
				pend_left = smcp_pkg::GainCount4;
				pend_kind = smcp_pkg::KIND_GAINS;
			end else if (b == pred_op[smcp_pkg::CfgOpStart]) begin
				run_flag = 1'b1;
				r.ev = smcp_pkg::EV_START;
			end else if (b == pred_op[smcp_pkg::CfgOpStop]) begin
				run_flag = 1'b0;
				r.ev = smcp_pkg::EV_STOP;
			end else if (b == pred_op[smcp_pkg::CfgOpSetpoint]) begin
				pend_left = smcp_pkg::SetpointCount4;
				pend_kind = smcp_pkg::KIND_SETPOINT;
			end
		end else begin
			// payload byte: opcodes are not looked at
			slot = wr_pos;
			if (slot >= smcp_pkg::StoreDepth)
				slot = slot % smcp_pkg::StoreDepth;
			pay_store[slot] = b;
			pend_left = pend_left - 4'd1;
			wr_pos = wr_pos + 4'd1;
			if (pend_left == 0) begin
				wr_pos = '0;
				if (pend_kind == smcp_pkg::KIND_GAINS) begin
					gain_word[0] = word_at(0);
					gain_word[1] = word_at(4);
					gain_word[2] = word_at(8);
					r.ev = smcp_pkg::EV_GAINS;
				end else begin
					target_word = word_at(0);
					r.ev = smcp_pkg::EV_SETPOINT;
				end
			end
		end
		r.run = run_flag;
		r.p = gain_word[0];
		r.i = gain_word[1];
		r.d = gain_word[2];
		r.t = target_word;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s at status beat %0d: expected %h, got %h",
					name, beats_checked, want, got);
		end
	endfunction

	// config beats, accepted bytes and result beats, all seen at the rising edge
	always @(posedge clk) begin
		result_t st;
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				pred_op[cfg_index] = cfg_data;
			// push before pop so an early result still finds its expectation
			if (in_valid && !in_stall) begin
				st = decode_byte(rx_byte);
				if (row_typed)
					st = row_status;
				ev_count[int'(st.ev)]++;
				queued_status.push_back(st);
			end
			if (out_valid && !out_stall) begin
				if (queued_status.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("status beat with no byte behind it: event %0d", event_res);
				end else begin
					want = queued_status.pop_front();
					check_field("event_res", 32'(want.ev), 32'(event_res));
					check_field("run_enable", 32'(want.run), 32'(run_enable));
					check_field("gain_p", want.p, gain_p);
					check_field("gain_i", want.i, gain_i);
					check_field("gain_d", want.d, gain_d);
					check_field("position_target", want.t, position_target);
				end
				beats_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d status beats outstanding",
				cycle_count, queued_status.size());
			$display("serial_motor_command_parser_tb failed");
			$finish;
		end
	end

	// receiver: random stall, a quiet stretch, and one long hold-off counted here
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_phase)
				hold_done = 1'b0;
			else if (!hold_done) begin
				hold_done = 1'b1;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else
				out_stall = !quiet && ($urandom_range(99) < IdlePct);
		end
	end

	// offer one byte beat, with random idle cycles in front, and hold it until taken
	task automatic offer_byte(logic [7:0] b, logic typed, result_t status);
		@(negedge clk);
		if (!quiet)
			while ($urandom_range(99) < IdlePct) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		in_valid = 1'b1;
		rx_byte = b;
		row_typed = typed;
		row_status = status;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// stop sending and wait for every outstanding status beat
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (queued_status.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_opcode(logic [smcp_pkg::CfgIdxW-1:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		cur_op[idx] = value;
	endtask

	task automatic load_opcodes(logic [7:0] og, logic [7:0] ost, logic [7:0] osp,
		logic [7:0] osetp);
		write_opcode(smcp_pkg::CfgOpGains, og);
		write_opcode(smcp_pkg::CfgOpStart, ost);
		write_opcode(smcp_pkg::CfgOpStop, osp);
		write_opcode(smcp_pkg::CfgOpSetpoint, osetp);
		@(negedge clk);
		cfg_valid = 1'b0;
		settings++;
	endtask

	// payload content leaning toward word extremes and opcode look-alikes
	function automatic logic [7:0] payload_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return $urandom_range(1) ? 8'h80 : 8'h7F;
			3: return cur_op[$urandom_range(3)];
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// one command: mostly well-formed, some cut short, some stray bytes
	task automatic send_command();
		int sel;
		int n;
		sel = $urandom_range(99);
		if (sel < 12)
			offer_byte(cur_op[smcp_pkg::CfgOpStart], 1'b0, '0);
		else if (sel < 24)
			offer_byte(cur_op[smcp_pkg::CfgOpStop], 1'b0, '0);
		else if (sel < 56) begin
			offer_byte(cur_op[smcp_pkg::CfgOpGains], 1'b0, '0);
			repeat (smcp_pkg::GainBytes) offer_byte(payload_byte(), 1'b0, '0);
		end else if (sel < 76) begin
			offer_byte(cur_op[smcp_pkg::CfgOpSetpoint], 1'b0, '0);
			repeat (smcp_pkg::SetpointBytes) offer_byte(payload_byte(), 1'b0, '0);
		end else if (sel < 88) begin
			// broken: payload cut short or, for setpoint, overrun; a short payload eats the next command
			n = $urandom_range(smcp_pkg::GainBytes - 1);
			offer_byte(sel[0] ? cur_op[smcp_pkg::CfgOpGains] : cur_op[smcp_pkg::CfgOpSetpoint],
				1'b0, '0);
			repeat (n) offer_byte(payload_byte(), 1'b0, '0);
		end else
			offer_byte(8'($urandom_range(255)), 1'b0, '0);
	endtask

	initial begin
		int phase_start;
		int left;
		bit paused;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		row_typed = 1'b0;
		row_status = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part under the reset opcodes
		foreach (directed_rows[k])
			offer_byte(directed_rows[k].rx, directed_rows[k].typed, directed_rows[k].status);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: load_opcodes(8'h00, 8'hFF, 8'h80, 8'h7F);          // extreme codes
				2: load_opcodes(8'h55, 8'h55, 8'h55, 8'h55);          // all equal: gains wins
				3: load_opcodes(8'hC3, 8'h3C, 8'h3C, 8'hFF);          // start shadows stop
				4: load_opcodes(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)));
				5: load_opcodes(smcp_pkg::RstOpGains, smcp_pkg::RstOpStart,
					smcp_pkg::RstOpStop, smcp_pkg::RstOpSetpoint);
				default: ;                                            // keep reset codes
			endcase
			quiet = (ph == 1);
			hold_phase = (ph == 2);
			paused = 1'b0;
			phase_start = items_sent;
			while (items_sent - phase_start < PhaseItems) begin
				send_command();
				// halfway through, let the parser run completely dry
				if (ph == 3 && !paused && items_sent - phase_start >= PhaseItems / 2) begin
					wait_drained();
					paused = 1'b1;
				end
			end
			wait_drained();
			// finish any open payload so the next opcode set starts from idle
			left = pend_left;
			repeat (left) offer_byte(payload_byte(), 1'b0, '0);
			wait_drained();
			hold_phase = 1'b0;
		end

		repeat (TailCycles) @(posedge clk);
		$display("%0d bytes sent (%0d directed) under %0d opcode settings",
			items_sent, $size(directed_rows), settings);
		$display("%0d status beats checked; events: %0d start, %0d stop, %0d gains, %0d setpoint",
			beats_checked, ev_count[smcp_pkg::EV_START], ev_count[smcp_pkg::EV_STOP],
			ev_count[smcp_pkg::EV_GAINS], ev_count[smcp_pkg::EV_SETPOINT]);
		if (mismatches == 0 && queued_status.size() == 0)
			$display("serial_motor_command_parser_tb passed");
		else
			$display("serial_motor_command_parser_tb failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/smcp_pkg.sv
rtl/smcp_payload.sv
rtl/serial_motor_command_parser.sv
sim/serial_motor_command_parser_tb.sv
